// ===== hw/rtl/stc_pkg.sv =====
package stc_pkg;

  // Widths of the item fields and of the capture counters.
  localparam int unsigned SampleW = 14;
  localparam int unsigned IndexW  = 9;
  localparam int unsigned CountW  = 11;
  localparam int unsigned OutCntW = 10;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 14;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 64;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] RegTrigSource = 2'd0;
  localparam logic [CfgAddrW-1:0] RegTrigX      = 2'd1;
  localparam logic [CfgAddrW-1:0] RegTrigY      = 2'd2;

  // Trigger source codes.
  localparam logic [1:0] SrcFree = 2'd0;
  localparam logic [1:0] SrcA    = 2'd1;
  localparam logic [1:0] SrcB    = 2'd2;
  localparam logic [1:0] SrcC    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [1:0]          TrigSourceRst = SrcA;
  localparam logic [IndexW-1:0]   TrigXRst      = 9'd160;
  localparam logic [SampleW-1:0]  TrigYRst      = 14'd8192;

  typedef struct packed {
    logic [1:0]         source;
    logic [IndexW-1:0]  trig_x;
    logic [SampleW-1:0] trig_y;
  } cfg_t;

  typedef struct packed {
    logic                clear_no_trigger;
    logic [IndexW-1:0]   read_index;
    logic                display_buffer;
    logic                display_busy;
    logic [SampleW-1:0]  sample_c;
    logic [SampleW-1:0]  sample_b;
    logic [SampleW-1:0]  sample_a;
  } in_item_t;

  typedef struct packed {
    logic                       no_trigger_flag;
    logic [IndexW-1:0]          draw_offset;
    logic signed [OutCntW-1:0]  captured_count;
    logic                       is_capturing;
    logic                       write_buffer;
  } status_t;

  typedef struct packed {
    logic [SampleW-1:0] c;
    logic [SampleW-1:0] b;
    logic [SampleW-1:0] a;
  } sample_set_t;

endpackage

// ===== hw/rtl/stc_ram.sv =====
module stc_ram #(
  parameter int unsigned Width = 42,
  parameter int unsigned Depth = 640
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port; the registered read returns the old word on a collision.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/stc_ctrl.sv =====
module stc_ctrl import stc_pkg::*; #(
  parameter int unsigned ScreenWidth    = 320,
  parameter int unsigned NoTriggerLimit = 1000,
  localparam int unsigned PosW  = $clog2(ScreenWidth),
  localparam int unsigned AddrW = $clog2(2 * ScreenWidth)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  in_item_t             item_i,
  input  cfg_t                 cfg_i,
  output logic                 we_o,
  output logic [AddrW-1:0]     waddr_o,
  output sample_set_t          wdata_o,
  output logic                 rd_ok_o,
  output logic [AddrW-1:0]     raddr_o,
  output status_t              status_o
);

  localparam logic [CountW-1:0] LastPos  = CountW'(ScreenWidth - 1);
  localparam logic [CountW-1:0] ScreenW  = CountW'(ScreenWidth);
  localparam logic [CountW-1:0] Limit    = CountW'(NoTriggerLimit);
  localparam logic [CountW-1:0] CntAll   = {CountW{1'b1}};

  // Capture state registers.
  logic               active_q, active_d;
  logic               sel_q, sel_d;
  logic [PosW-1:0]    wpos_q, wpos_d;
  logic [CountW-1:0]  pretrig_q, pretrig_d;
  logic [SampleW-1:0] prev_q, prev_d;
  logic [PosW-1:0]    offset_q [2];
  logic [PosW-1:0]    offset_d [2];
  logic [CountW-1:0]  count_q [2];
  logic [CountW-1:0]  count_d [2];
  logic               forced_q, forced_d;

  // Next state for one accepted item, in the order the capture rules apply.
  always_comb begin
    logic [CountW-1:0]  tx;
    logic [CountW-1:0]  wpos_ext;
    logic [CountW-1:0]  off;
    logic [SampleW-1:0] cur;
    logic               trig;
    logic               wr;
    logic [CountW-1:0]  wpos_new;

    active_d    = active_q;
    sel_d       = sel_q;
    wpos_d      = wpos_q;
    pretrig_d   = pretrig_q;
    prev_d      = prev_q;
    offset_d[0] = offset_q[0];
    offset_d[1] = offset_q[1];
    count_d[0]  = count_q[0];
    count_d[1]  = count_q[1];
    forced_d    = forced_q;

    tx = (CountW'(cfg_i.trig_x) > LastPos) ? LastPos : CountW'(cfg_i.trig_x);
    wpos_ext = CountW'(wpos_q);
    off = (wpos_ext >= tx) ? (wpos_ext - tx) : (wpos_ext + ScreenW - tx);

    case (cfg_i.source)
      SrcA:    cur = item_i.sample_a;
      SrcB:    cur = item_i.sample_b;
      default: cur = item_i.sample_c;
    endcase

    if (item_i.clear_no_trigger) begin
      forced_d = 1'b0;
    end

    // Trigger: rising crossing of the level after enough pre-trigger samples, or at once in free-run mode.
    trig = !active_q && (!item_i.display_busy || (sel_q != item_i.display_buffer)) &&
           ((cfg_i.source == SrcFree) ||
            ((pretrig_q > tx) && (prev_q < cfg_i.trig_y) && (cur >= cfg_i.trig_y)));
    if (trig) begin
      active_d = 1'b1;
      if (cfg_i.source == SrcFree) begin
        wpos_d          = '0;
        offset_d[sel_q] = '0;
        count_d[sel_q]  = CntAll;
      end else begin
        offset_d[sel_q] = PosW'(off);
        count_d[sel_q]  = tx - CountW'(1);
      end
    end

    // A full buffer ends the capture and swaps buffers.
    if (active_d && (count_d[sel_d] == LastPos)) begin
      sel_d     = !sel_d;
      pretrig_d = '0;
      active_d  = 1'b0;
    end

    wr = active_d || !item_i.display_busy || (sel_d != item_i.display_buffer);
    we_o    = accept_i && wr;
    waddr_o = sel_d ? (AddrW'(ScreenWidth) + AddrW'(wpos_d)) : AddrW'(wpos_d);
    wdata_o = '{c: item_i.sample_c, b: item_i.sample_b, a: item_i.sample_a};

    wpos_new = (CountW'(wpos_d) >= LastPos) ? '0 : (CountW'(wpos_d) + CountW'(1));
    if (wr) begin
      if (cfg_i.source != SrcFree) begin
        prev_d = cur;
      end
      wpos_d = PosW'(wpos_new);
      count_d[sel_d] = count_d[sel_d] + CountW'(1);
      if (!active_d) begin
        pretrig_d = pretrig_d + CountW'(1);
        // No trigger for too long: force the buffer out at the wrap point.
        if ((pretrig_d > Limit) && (wpos_new == '0)) begin
          sel_d           = !sel_d;
          pretrig_d       = '0;
          offset_d[sel_d] = '0;
          forced_d        = 1'b1;
        end
      end
    end

    // Display read port and the status fields after this item.
    rd_ok_o = (CountW'(item_i.read_index) < ScreenW);
    raddr_o = item_i.display_buffer ? (AddrW'(ScreenWidth) + AddrW'(item_i.read_index))
                                    : AddrW'(item_i.read_index);
    status_o.write_buffer    = sel_d;
    status_o.is_capturing    = active_d;
    status_o.captured_count  = OutCntW'(count_d[sel_d]);
    status_o.draw_offset     = IndexW'(offset_d[item_i.display_buffer]);
    status_o.no_trigger_flag = forced_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      sel_q       <= 1'b0;
      wpos_q      <= '0;
      pretrig_q   <= '0;
      prev_q      <= '0;
      offset_q[0] <= '0;
      offset_q[1] <= '0;
      count_q[0]  <= '0;
      count_q[1]  <= '0;
      forced_q    <= 1'b0;
    end else if (accept_i) begin
      active_q    <= active_d;
      sel_q       <= sel_d;
      wpos_q      <= wpos_d;
      pretrig_q   <= pretrig_d;
      prev_q      <= prev_d;
      offset_q[0] <= offset_d[0];
      offset_q[1] <= offset_d[1];
      count_q[0]  <= count_d[0];
      count_q[1]  <= count_d[1];
      forced_q    <= forced_d;
    end
  end

endmodule

// ===== hw/rtl/scope_trigger_capture.sv =====
// Three-channel scope capture engine. Each input item carries one summed sample per
// channel plus the display side's read request; each item yields exactly one result
// item with the stored samples at read_index of the displayed buffer (as they were
// before this item's write) and the capture status after the item. The engine takes
// one item per clock cycle while the result side accepts; a result passes through the
// registered read of the sample memory and then the output register. The three
// channels share one memory word of 2 x SCREEN_WIDTH entries with one write and one
// read port; a read and a write of the same entry return the old sample. The memory
// is not cleared after reset, so an entry read before it was ever written returns
// undefined data. Configuration writes apply to the next item taken.
module scope_trigger_capture import stc_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH     = 320,
  parameter int unsigned NO_TRIGGER_LIMIT = 1000
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port.
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // Input items.
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // sample_a[13:0], sample_b[27:14], sample_c[41:28], display_busy[42],
  // display_buffer[43], read_index[52:44], clear_no_trigger[53], zero[55:54]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // Result items.
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // read_a[13:0], read_b[27:14], read_c[41:28], write_buffer[42],
  // is_capturing[43], captured_count[53:44], draw_offset[62:54], no_trigger_flag[63]
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned AddrW = $clog2(2 * SCREEN_WIDTH);
  localparam int unsigned WordW = 3 * SampleW;

  cfg_t        cfg_q;
  in_item_t    item;
  logic        accept;
  logic        we;
  logic [AddrW-1:0] waddr;
  sample_set_t wdata;
  logic        rd_ok;
  logic [AddrW-1:0] raddr;
  status_t     status;
  logic [WordW-1:0] rdata;
  sample_set_t rd_set;

  // Read stage and output register.
  logic        s1_valid_q;
  logic        s1_rd_ok_q;
  status_t     s1_status_q;
  logic        out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic        s1_advance;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source <= TrigSourceRst;
      cfg_q.trig_x <= TrigXRst;
      cfg_q.trig_y <= TrigYRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegTrigSource: cfg_q.source <= cfg_wdata_i[1:0];
        RegTrigX:      cfg_q.trig_x <= cfg_wdata_i[IndexW-1:0];
        RegTrigY:      cfg_q.trig_y <= cfg_wdata_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  assign item   = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
  assign s1_advance    = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  stc_ctrl #(
    .ScreenWidth    (SCREEN_WIDTH),
    .NoTriggerLimit (NO_TRIGGER_LIMIT)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg_q),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .rd_ok_o  (rd_ok),
    .raddr_o  (raddr),
    .status_o (status)
  );

  stc_ram #(
    .Width (WordW),
    .Depth (2 * SCREEN_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept && rd_ok),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Read stage: status waits here while the memory read completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rd_ok_q  <= rd_ok;
      s1_status_q <= status;
    end
  end

  // Out-of-range read positions return zero samples.
  assign rd_set = s1_rd_ok_q ? sample_set_t'(rdata) : '0;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && s1_valid_q) begin
      out_data_q <= {s1_status_q, rd_set};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
